>>> hw/rtl/dstq_pkg.sv
package dstq_pkg;

   localparam int DSTQ_DEPTH = 16;
   localparam int ENTRY_COUNT_W = 5;

   localparam logic [1:0] ACT_INSERT = 2'd0;
   localparam logic [1:0] ACT_REMOVE = 2'd1;
   localparam logic [1:0] ACT_UPDATE = 2'd2;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;

   localparam logic [1:0] OP_HOLD = 2'd0;
   localparam logic [1:0] OP_INSERT = 2'd1;
   localparam logic [1:0] OP_REMOVE = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [19:0] task_id;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [15:0] duration;
      logic [7:0]  priority_req;
   } req_type;

   typedef struct packed {
      logic [1:0]                 status;
      logic [ENTRY_COUNT_W-1:0]   entry_count;
      logic                       head_valid;
      logic [19:0]                head_task_id;
   } rsp_type;

   typedef struct packed {
      logic [19:0] task_id;
      logic [31:0] deadline;
      logic [23:0] payload;
   } entry_type;

   typedef struct packed {
      logic [1:0] op;
      entry_type  entry;
   } cell_cmd_type;

   typedef struct packed {
      logic insert_here;
      logic removed;
   } link_type;

endpackage

>>> hw/rtl/dstq_cell.sv
module dstq_cell (
   input  logic                   clock,
   input  dstq_pkg::cell_cmd_type cmd,
   input  logic                   occupied,
   input  dstq_pkg::link_type     prev_link,
   input  dstq_pkg::entry_type    prev_entry,
   input  dstq_pkg::entry_type    next_entry,
   output dstq_pkg::link_type     link,
   output dstq_pkg::entry_type    entry
);
   import dstq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      later;
   logic      match;

   always_comb begin
      later = occupied && (entry_ff.deadline > cmd.entry.deadline);
      match = occupied && (entry_ff.task_id == cmd.entry.task_id);
      link.insert_here = !occupied || later;
      link.removed = prev_link.removed || match;
      entry_in = entry_ff;
      case (cmd.op)
         OP_INSERT: begin
            if (link.insert_here) begin
               entry_in = prev_link.insert_here ? prev_entry : cmd.entry;
            end
         end
         OP_REMOVE: begin
            if (link.removed) begin
               entry_in = next_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

>>> hw/rtl/deadline_sorted_task_queue.sv
// Deadline-sorted task queue.
// The request channel (req_valid, req_ready, req_data) takes one command per
// beat: insert, remove by ID, or update by ID. The response channel
// (rsp_valid, rsp_ready, rsp_data) returns one beat per command with the
// status, the number of tasks held and the ID of the task at the head.
// Tasks sit in a row of cells kept in deadline order, earliest at cell 0.
// Every cell compares its deadline or ID against the command in parallel
// and shifts toward its neighbor, so an insert or a remove moves the whole
// row at once. A command is registered on acceptance and executed from that
// register once the output register is free; the response is registered in
// the output register, and an update removes and then reinserts the task.
// The block accepts a new command only once the last one has executed.
// Reset empties the queue and drops any pending response.
// While the receiver stalls, the finished response holds in the output
// register; the next command is still accepted and waits until the output
// register is free before it executes.
module deadline_sorted_task_queue #(
   parameter int QUEUE_DEPTH = dstq_pkg::DSTQ_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dstq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dstq_pkg::rsp_type rsp_data
);
   import dstq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(QUEUE_DEPTH);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN = 2'd1;
   localparam logic [1:0] S_REINS = 2'd2;

   logic [1:0]   state_ff, state_in;
   req_type      req_ff, req_in;
   logic [CW-1:0] count_ff, count_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_type      rsp_ff, rsp_in;

   cell_cmd_type cmd;
   link_type     links [QUEUE_DEPTH];
   link_type     prev_links [QUEUE_DEPTH];
   entry_type    ents [QUEUE_DEPTH];
   entry_type    prev_ents [QUEUE_DEPTH];
   entry_type    next_ents [QUEUE_DEPTH];

   logic         slot_free;
   logic         finish;
   logic [1:0]   status;
   logic [19:0]  head_id;

   genvar i;
   generate
      for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
         if (i == 0) begin : g_first
            assign prev_links[i] = '0;
            assign prev_ents[i] = ents[i];
         end else begin : g_rest
            assign prev_links[i] = links[i-1];
            assign prev_ents[i] = ents[i-1];
         end
         if (i == QUEUE_DEPTH - 1) begin : g_last
            assign next_ents[i] = ents[i];
         end else begin : g_inner
            assign next_ents[i] = ents[i+1];
         end
         dstq_cell u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .occupied   (CW'(i) < count_ff),
            .prev_link  (prev_links[i]),
            .prev_entry (prev_ents[i]),
            .next_entry (next_ents[i]),
            .link       (links[i]),
            .entry      (ents[i])
         );
      end
   endgenerate

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      count_in = count_ff;
      finish = 1'b0;
      status = ST_OK;
      cmd.op = OP_HOLD;
      cmd.entry.task_id = req_ff.task_id;
      cmd.entry.deadline = {req_ff.year, req_ff.month, req_ff.day, req_ff.hour,
                            req_ff.minute};
      cmd.entry.payload = {req_ff.duration, req_ff.priority_req};
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (slot_free) begin
               case (req_ff.action)
                  ACT_INSERT: begin
                     finish = 1'b1;
                     if (count_ff == FULL_COUNT) begin
                        status = ST_FULL;
                     end else begin
                        cmd.op = OP_INSERT;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  ACT_REMOVE, ACT_UPDATE: begin
                     cmd.op = OP_REMOVE;
                     if (links[QUEUE_DEPTH-1].removed) begin
                        count_in = count_ff - CW'(1);
                        if (req_ff.action == ACT_UPDATE) begin
                           state_in = S_REINS;
                        end else begin
                           finish = 1'b1;
                        end
                     end else begin
                        status = ST_NOT_FOUND;
                        finish = 1'b1;
                     end
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end
         S_REINS: begin
            if (slot_free) begin
               cmd.op = OP_INSERT;
               count_in = count_ff + CW'(1);
               finish = 1'b1;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (finish) begin
         state_in = S_IDLE;
      end

      case (cmd.op)
         OP_INSERT: head_id = links[0].insert_here ? cmd.entry.task_id : ents[0].task_id;
         OP_REMOVE: head_id = links[0].removed ? next_ents[0].task_id : ents[0].task_id;
         default:   head_id = ents[0].task_id;
      endcase

      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         rsp_in.status = status;
         rsp_in.entry_count = ENTRY_COUNT_W'(count_in);
         rsp_in.head_valid = (count_in != '0);
         rsp_in.head_task_id = (count_in != '0) ? head_id : 20'd0;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

>>> hw/rtl/dstq_checker.sv
module dstq_checker #(
   parameter int QUEUE_DEPTH = dstq_pkg::DSTQ_DEPTH
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input dstq_pkg::rsp_type rsp_data
);
   import dstq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("Response beat changed while stalled.");

   a_head_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.head_valid == (rsp_data.entry_count != '0))
      else $error("Head flag disagrees with entry count.");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.head_valid |-> rsp_data.head_task_id == 20'd0)
      else $error("Empty queue reports a nonzero head ID.");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_FULL
         |-> rsp_data.entry_count == ENTRY_COUNT_W'(QUEUE_DEPTH))
      else $error("Full status with a queue that is not full.");

   a_req_idle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("Second request accepted before the first executed.");

endmodule

bind deadline_sorted_task_queue dstq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dstq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
